// ===== hdl/elevator_request_scheduler_defines.svh =====
// Assertion macros shared by the elevator request scheduler RTL.
`ifndef ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH
`define ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ers_pkg.sv =====
// Shared types and constants of the elevator request scheduler.
package ers_pkg;

  localparam int unsigned MAX_PENDING_DEF = 16;

  localparam int unsigned FLOOR_W = 8;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned OUT_W   = 24;

  localparam logic signed [FLOOR_W-1:0] LOWEST_RST  = 8'sd0;
  localparam logic signed [FLOOR_W-1:0] HIGHEST_RST = 8'sd15;
  localparam logic [CAP_W-1:0]          CAP_RST     = 5'd8;

  typedef enum logic [1:0] {
    CFG_LOWEST   = 2'd0,
    CFG_HIGHEST  = 2'd1,
    CFG_CAPACITY = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BEHIND_UP   = 3'd2,
    STAT_BEHIND_DOWN = 3'd3,
    STAT_NO_FLOOR    = 3'd4,
    STAT_NOTHING     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_SCAN,
    ST_MV_FIND,
    ST_MV_DROP,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/elevator_request_scheduler.sv =====
// Elevator request scheduler: pending-floor memory with a scanning sequencer.
// A rejected request or an empty move goes from the idle state straight to the done state;
// a stored request first walks the table to the first free slot;
// a move makes one read pass to pick the stop and one to drop it, then reaches the done state.
// One word is processed at a time; the memory read port and the slot scan set the pace.
// Reset (async, active low): table empty, car at floor 0 going up, registers at defaults.
`include "elevator_request_scheduler_defines.svh"

module elevator_request_scheduler #(
  parameter int unsigned MAX_PENDING = ers_pkg::MAX_PENDING_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ers_pkg::CFG_W-1:0]  cfg_data_i,
  // input word stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] floor
  input  logic                       s_axis_tuser,  // [0] op: 0 request, 1 move
  // result word stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [2:0] status, [10:3] at_floor, [11] going_down, [16:12] load,
  // [21:17] dropped, [23:22] zero
  output logic [ers_pkg::OUT_W-1:0]  m_axis_tdata
);
  import ers_pkg::*;

  // Slot index width, count width (must hold MAX_PENDING itself), count/capacity compare width.
  localparam int unsigned IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int unsigned CW = $clog2(MAX_PENDING + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PENDING - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PENDING);

  // Configuration registers.
  logic signed [FLOOR_W-1:0] low_q, high_q;
  logic [CAP_W-1:0]          cap_q;

  // Scheduler state.
  state_e                    state_q, state_d;
  logic [MAX_PENDING-1:0]    valid_q, valid_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic signed [FLOOR_W-1:0] car_q, car_d;
  logic                      down_q, down_d;

  // Sequencer working registers.
  logic [IW-1:0]             ptr_q, ptr_d;
  logic                      iss_q, iss_d;        // read pass still issuing
  logic                      rd_v_q, rd_v_d;      // read data valid next cycle
  logic [IW-1:0]             rd_idx_q, rd_idx_d;
  logic signed [FLOOR_W-1:0] floor_q, floor_d;
  logic signed [FLOOR_W-1:0] target_q, target_d;
  logic                      found_q, found_d;
  logic [CW-1:0]             drop_q, drop_d;
  status_e                   status_q, status_d;

  // Output register.
  logic                      ov_q, ov_d;
  logic [OUT_W-1:0]          odata_q, odata_d;

  // Pending-floor memory: one write or one read port access per cycle.
  logic [FLOOR_W-1:0]        mem [MAX_PENDING];
  logic signed [FLOOR_W-1:0] rdata_q;
  logic                      mem_we, mem_re;
  logic [IW-1:0]             mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= floor_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Configuration writes; indices beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOWEST_RST;
      high_q <= HIGHEST_RST;
      cap_q  <= CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LOWEST:   low_q  <= cfg_data_i;
        CFG_HIGHEST:  high_q <= cfg_data_i;
        CFG_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  logic                      in_acc;
  logic signed [FLOOR_W-1:0] in_floor;
  logic [LW-1:0]             cnt_ext, cap_ext, drop_ext;
  logic [CW-1:0]             drop_tot;
  logic                      hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_floor      = s_axis_tdata;
  assign cnt_ext       = LW'(cnt_q);
  assign cap_ext       = LW'(cap_q);
  assign drop_ext      = LW'(drop_q);

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    car_d    = car_q;
    down_d   = down_q;
    ptr_d    = ptr_q;
    iss_d    = iss_q;
    rd_v_d   = 1'b0;
    rd_idx_d = rd_idx_q;
    floor_d  = floor_q;
    target_d = target_q;
    found_d  = found_q;
    drop_d   = drop_q;
    status_d = status_q;
    ov_d     = ov_q && !m_axis_tready;
    odata_d  = odata_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = ptr_q;
    hit      = 1'b0;
    drop_tot = drop_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          floor_d  = in_floor;
          ptr_d    = '0;
          drop_d   = '0;
          found_d  = 1'b0;
          status_d = STAT_OK;
          if (!s_axis_tuser) begin
            state_d = ST_REQ_SCAN;
            if (cnt_q == '0) begin
              // Empty table: store unchecked and steer toward the request.
              if (in_floor > car_q) begin
                down_d = 1'b0;
              end else if (in_floor < car_q) begin
                down_d = 1'b1;
              end
            end else if (cnt_ext >= cap_ext || cnt_q >= FULL_CNT) begin
              status_d = STAT_FULL;
              state_d  = ST_DONE;
            end else if (!down_q && in_floor < car_q) begin
              status_d = STAT_BEHIND_UP;
              state_d  = ST_DONE;
            end else if (down_q && in_floor > car_q) begin
              status_d = STAT_BEHIND_DOWN;
              state_d  = ST_DONE;
            end else if (in_floor > high_q || in_floor < low_q) begin
              status_d = STAT_NO_FLOOR;
              state_d  = ST_DONE;
            end
          end else if (cnt_q == '0) begin
            status_d = STAT_NOTHING;
            state_d  = ST_DONE;
          end else begin
            iss_d   = 1'b1;
            state_d = ST_MV_FIND;
          end
        end
      end

      ST_REQ_SCAN: begin
        // Walk to the first free slot; one is known to exist.
        if (!valid_q[ptr_q]) begin
          mem_we          = 1'b1;
          valid_d[ptr_q]  = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          state_d         = ST_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_MV_FIND: begin
        if (iss_q) begin
          mem_re   = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = ptr_q;
          if (ptr_q == LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        // Track the nearest stop in the travel direction.
        if (rd_v_q && valid_q[rd_idx_q]) begin
          if (!found_q || (down_q ? (rdata_q > target_q) : (rdata_q < target_q))) begin
            target_d = rdata_q;
            found_d  = 1'b1;
          end
        end
        if (rd_v_q && rd_idx_q == LAST_IDX) begin
          ptr_d   = '0;
          iss_d   = 1'b1;
          state_d = ST_MV_DROP;
        end
      end

      ST_MV_DROP: begin
        if (iss_q) begin
          mem_re   = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = ptr_q;
          if (ptr_q == LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        // Clear every request for the stop floor.
        hit = rd_v_q && valid_q[rd_idx_q] && (rdata_q == target_q);
        if (hit) begin
          valid_d[rd_idx_q] = 1'b0;
        end
        drop_tot = drop_q + CW'(hit);
        drop_d   = drop_tot;
        if (rd_v_q && rd_idx_q == LAST_IDX) begin
          cnt_d = cnt_q - drop_tot;
          car_d = target_q;
          if (target_q == high_q) begin
            down_d = 1'b1;
          end else if (target_q == low_q) begin
            down_d = 1'b0;
          end
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the word over once the output register is free.
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          odata_d = {2'b00, drop_ext[4:0], cnt_ext[4:0], down_q, car_q, status_q};
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      car_q   <= '0;
      down_q  <= 1'b0;
      iss_q   <= 1'b0;
      rd_v_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      car_q   <= car_d;
      down_q  <= down_d;
      iss_q   <= iss_d;
      rd_v_q  <= rd_v_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    rd_idx_q <= rd_idx_d;
    floor_q  <= floor_d;
    target_q <= target_d;
    found_q  <= found_d;
    drop_q   <= drop_d;
    status_q <= status_d;
    odata_q  <= odata_d;
  end

  `ERS_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= FULL_CNT, "pending count overflow")
  `ERS_ASSERT_NOW(a_cnt_match, clk_i, rst_ni, state_q == ST_IDLE,
                  $countones(valid_q) == int'(cnt_q), "pending count disagrees with table")
  `ERS_ASSERT_NOW(a_free_slot, clk_i, rst_ni, state_q == ST_REQ_SCAN,
                  cnt_q < FULL_CNT, "store started on a full table")
  `ERS_ASSERT_NOW(a_stop_found, clk_i, rst_ni, state_q == ST_MV_DROP,
                  found_q, "drop pass without a chosen stop")

endmodule
